// File: rtl/core/rns_pkg.sv
// shared types and constants for the radius neighbour search
package rns_pkg;
  localparam int CoordBits = 24;
  localparam int RadBits = 23;
  localparam int IdxBits = 12;
  localparam int CntBits = 13;
  localparam int SqBits = 48;
  localparam int DistBits = 24;
  localparam int QuoBits = 36;
  localparam int MaxNodes = 4096;
  localparam logic [RadBits-1:0] ScaleMax = 23'h7fffff;

  typedef enum logic [2:0] {
    REG_CX = 3'd0, REG_CY = 3'd1, REG_CZ = 3'd2, REG_RAD = 3'd3,
    REG_DC = 3'd4, REG_MODE = 3'd5, REG_DLO = 3'd6, REG_DHI = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TEST, ST_SQRT, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic test;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scale;
    logic sqrt_done;
    logic div_done;
  } sts_t;
endpackage

// File: rtl/core/rns_ctrl.sv
// controller state machine of the radius neighbour search
module rns_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  rns_pkg::sts_t sts,
  output rns_pkg::cmd_t cmd
);
  import rns_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd.test = 1'b1;
        if (sts.need_scale) begin
          cmd.sqrt_init = 1'b1;
          state_nxt = ST_SQRT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.emit = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/core/rns_datapath.sv
// distance test, accumulators, root and divide unit
module rns_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [47:0]                cfg_wdata,
  input  logic [87:0]                in_tdata,
  input  logic                       in_tlast,
  input  rns_pkg::cmd_t              cmd,
  output rns_pkg::sts_t              sts,
  output logic [55:0]                out_tdata,
  output logic                       out_tlast
);
  import rns_pkg::*;

  logic signed [CoordBits-1:0] cx_r, cy_r, cz_r;
  logic [RadBits-1:0] rad_r, dc_r;
  logic mode_r;
  logic [47:0] dlo_r, dhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0; rad_r <= '0;
      dc_r <= 23'd4096; mode_r <= 1'b0; dlo_r <= '0; dhi_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CX:   cx_r <= cfg_wdata[23:0];
        REG_CY:   cy_r <= cfg_wdata[23:0];
        REG_CZ:   cz_r <= cfg_wdata[23:0];
        REG_RAD:  rad_r <= cfg_wdata[22:0];
        REG_DC:   dc_r <= cfg_wdata[22:0];
        REG_MODE: mode_r <= cfg_wdata[0];
        REG_DLO:  dlo_r <= cfg_wdata;
        REG_DHI:  dhi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input item capture with absolute differences
  logic signed [CoordBits-1:0] nx_r, ny_r;
  logic [IdxBits-1:0] idx_r;
  logic last_r;
  logic [24:0] ax_r, ay_r, az_r;
  logic signed [25:0] dx, dy, dz;

  assign dx = 26'(signed'(in_tdata[23:0])) - 26'(cx_r);
  assign dy = 26'(signed'(in_tdata[47:24])) - 26'(cy_r);
  assign dz = 26'(signed'(in_tdata[71:48])) - 26'(cz_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx_r <= in_tdata[23:0];
      ny_r <= in_tdata[47:24];
      idx_r <= in_tdata[83:72];
      last_r <= in_tlast;
      ax_r <= dx[25] ? 25'(-dx) : dx[24:0];
      ay_r <= dy[25] ? 25'(-dy) : dy[24:0];
      az_r <= dz[25] ? 25'(-dz) : dz[24:0];
    end
  end

  // box limits
  function automatic void clamp(input logic signed [25:0] c, input logic signed [25:0] r,
      input logic signed [25:0] dmin, input logic signed [25:0] dmax,
      output logic signed [25:0] lo, output logic signed [25:0] hi);
    if (c - r < dmin) begin
      lo = dmin; hi = dmin + (r <<< 1);
    end else if (c + r > dmax) begin
      hi = dmax; lo = dmax - (r <<< 1);
    end else begin
      lo = c - r; hi = c + r;
    end
  endfunction

  logic signed [25:0] rs, lox, hix, loy, hiy, nxs, nys;
  logic in_box, rect_sel, rad_sel;
  logic [49:0] sq;
  logic [45:0] rr;
  assign rs = 26'(rad_r);
  assign nxs = 26'(nx_r);
  assign nys = 26'(ny_r);
  always_comb begin
    clamp(26'(cx_r), rs, 26'(signed'(dlo_r[23:0])), 26'(signed'(dhi_r[23:0])), lox, hix);
    clamp(26'(cy_r), rs, 26'(signed'(dlo_r[47:24])), 26'(signed'(dhi_r[47:24])), loy, hiy);
  end
  assign in_box = ax_r <= 25'(rad_r) && ay_r <= 25'(rad_r);
  assign rect_sel = nxs >= lox && nxs <= hix && nys >= loy && nys <= hiy;
  assign sq = 50'(ax_r * ax_r) + 50'(ay_r * ay_r) + 50'(az_r * az_r);
  assign rr = rad_r * rad_r;
  assign rad_sel = in_box && az_r <= 25'(rad_r) && sq <= 50'(rr);

  logic [SqBits-1:0] max_r;
  logic [CntBits-1:0] cnt_r, cnt_out_r;
  logic sel_r, sv_r;
  logic [RadBits-1:0] scale_r;
  logic sel_now;
  assign sel_now = mode_r ? rect_sel : rad_sel;

  // restoring root and divide sharing one iteration counter
  logic [SqBits-1:0] rem_r;
  logic [DistBits-1:0] root_r;
  logic [QuoBits-1:0] quo_r, num_r;
  logic [RadBits:0] drem_r;
  logic [5:0] it_r;
  logic [RadBits+1:0] dtry;

  logic [DistBits+1:0] rem_hi_nxt;
  logic [DistBits-1:0] acc_r;
  logic [DistBits+1:0] tr;
  assign rem_hi_nxt = {acc_r, rem_r[SqBits-1:SqBits-2]};
  assign tr = {root_r, 2'b01};
  assign dtry = {drem_r, num_r[QuoBits-1]} - {1'b0, 1'b0, dc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0; cnt_r <= '0;
    end else if (cmd.test) begin
      if (last_r) begin
        max_r <= '0; cnt_r <= '0;
      end else begin
        if (sel_now && !mode_r && 48'(sq) > max_r) max_r <= 48'(sq);
        if (sel_now && cnt_r < CntBits'(MaxNodes)) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      sel_r <= sel_now;
      cnt_out_r <= (sel_now && cnt_r < CntBits'(MaxNodes)) ? cnt_r + 1'b1 : cnt_r;
      sv_r <= last_r && !mode_r;
      scale_r <= '0;
      rem_r <= (sel_now && !mode_r && 48'(sq) > max_r) ? 48'(sq) : max_r;
    end
    if (cmd.sqrt_init) begin
      acc_r <= '0; root_r <= '0; it_r <= '0;
    end
    if (cmd.sqrt_step) begin
      if (rem_hi_nxt >= tr) begin
        acc_r <= DistBits'(rem_hi_nxt - tr);
        root_r <= {root_r[DistBits-2:0], 1'b1};
      end else begin
        acc_r <= DistBits'(rem_hi_nxt);
        root_r <= {root_r[DistBits-2:0], 1'b0};
      end
      rem_r <= {rem_r[SqBits-3:0], 2'b00};
      it_r <= it_r + 1'b1;
    end
    if (cmd.div_init) begin
      num_r <= {root_r, 12'd0}; drem_r <= '0; quo_r <= '0; it_r <= '0;
    end
    if (cmd.div_step) begin
      if (!dtry[RadBits+1]) begin
        drem_r <= dtry[RadBits:0];
        quo_r <= {quo_r[QuoBits-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[RadBits-1:0], num_r[QuoBits-1]};
        quo_r <= {quo_r[QuoBits-2:0], 1'b0};
      end
      num_r <= {num_r[QuoBits-2:0], 1'b0};
      it_r <= it_r + 1'b1;
    end
    if (cmd.emit) begin
      if (dc_r == '0 || quo_r[QuoBits-1:RadBits] != '0) scale_r <= ScaleMax;
      else scale_r <= quo_r[RadBits-1:0];
    end
  end

  assign sts.need_scale = last_r && !mode_r;
  assign sts.sqrt_done = it_r == 6'(DistBits);
  assign sts.div_done = it_r == 6'(QuoBits);
  assign out_tdata = {6'd0, sv_r, scale_r, cnt_out_r, sel_r, idx_r};
  assign out_tlast = last_r;
endmodule

// File: rtl/core/radius_neighbor_search.sv
// radius neighbour search top level
// flow: the input item is captured on load, tested in the TEST state and presented in the OUT state;
// a radius-mode last item also passes through the root (SQRT) and divide (DIV) states before OUT
// the controller takes no new item until the current result is accepted, handing each item
// through test and, for a radius-mode last item, root and divide before the next is taken
// reset: synchronous active low, registers to defaults, count and maximum cleared
module radius_neighbor_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // node_x, node_y, node_z, node_index
  input  logic        in_tlast,   // last_node
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // result_index, selected, support_count, new_scale, scale_valid
  output logic        out_tlast   // result_last
);
  import rns_pkg::*;
  cmd_t cmd;
  sts_t sts;

  rns_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );
  rns_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_tdata, .in_tlast, .cmd, .sts,
    .out_tdata, .out_tlast
  );
endmodule
